// ===== hw/rtl/bba_pkg.sv =====
// buddy block allocator: shared types, op and status codes, command kinds
// no dependencies
`timescale 1ns / 1ps

package bba_pkg;

  // op codes of an input word
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // status codes of a result word
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  // command kinds from the front end to the engine
  localparam logic [2:0] CMD_NOP       = 3'd0;
  localparam logic [2:0] CMD_ALLOC     = 3'd1;
  localparam logic [2:0] CMD_FREE      = 3'd2;
  localparam logic [2:0] CMD_RESET     = 3'd3;
  localparam logic [2:0] CMD_TOO_LARGE = 3'd4;
  localparam logic [2:0] CMD_BAD_FREE  = 3'd5;

  // free bitmaps are kept in rows of 2^WORD_LOG2 bits
  localparam int WORD_LOG2 = 7;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] request_bytes;
    logic [14:0] user_offset;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] granted_offset;
    logic [3:0]  granted_order;
  } bba_out_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  order;
    logic [14:0] slot;
    logic [14:0] user_offset;
  } bba_cmd_t;

  typedef struct packed {
    logic busy;
    logic res_load;
  } bba_bk_sts_t;

endpackage

// ===== hw/rtl/bba_front.sv =====
// buddy block allocator front end: decodes an input word into a command
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_front #(
  parameter int HEADER_LOG2 = 3,
  parameter int ORDERS      = 12
) (
  input  bba_pkg::bba_in_t  in_word,
  output bba_pkg::bba_cmd_t cmd
);

  localparam int MIN_LOG2  = HEADER_LOG2 + 1;
  localparam int HDR       = 1 << HEADER_LOG2;
  localparam int LEAF_LOG2 = ORDERS - 1;

  always_comb begin
    logic [16:0] need;
    logic [4:0]  k;
    logic [14:0] start;
    logic [31:0] slot_w;
    need   = {1'b0, in_word.request_bytes} + 17'(HDR);
    // smallest order whose block holds the request plus header
    k      = '0;
    for (int o = 0; o < ORDERS; o++) begin
      if ((32'd1 << (o + MIN_LOG2)) < 32'(need)) k = k + 5'd1;
    end
    start  = in_word.user_offset - 15'(HDR);
    slot_w = 32'(start) >> MIN_LOG2;
    cmd             = '0;
    cmd.slot        = slot_w[14:0];
    cmd.user_offset = in_word.user_offset;
    unique case (in_word.op)
      bba_pkg::OP_ALLOC: begin
        if (k == 5'(ORDERS)) begin
          cmd.kind = bba_pkg::CMD_TOO_LARGE;
        end else begin
          cmd.kind  = bba_pkg::CMD_ALLOC;
          cmd.order = k[3:0];
        end
      end
      bba_pkg::OP_FREE: begin
        if ((in_word.user_offset < 15'(HDR)) || (start[MIN_LOG2-1:0] != '0) ||
            ((slot_w >> LEAF_LOG2) != 32'd0)) begin
          cmd.kind = bba_pkg::CMD_BAD_FREE;
        end else begin
          cmd.kind = bba_pkg::CMD_FREE;
        end
      end
      bba_pkg::OP_RESET: cmd.kind = bba_pkg::CMD_RESET;
      default:           cmd.kind = bba_pkg::CMD_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/bba_queue.sv =====
// buddy block allocator: two-entry command queue between front end and engine
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bba_pkg::bba_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output bba_pkg::bba_cmd_t head_cmd
);

  bba_pkg::bba_cmd_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = ent_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_cmd;
  end

endmodule

// ===== hw/rtl/bba_back.sv =====
// buddy block allocator engine: free bitmaps per order, slot tables,
// search, split and merge sequencer, result register; depends on bba_pkg
`timescale 1ns / 1ps

module bba_back #(
  parameter int HEADER_LOG2 = 3,
  parameter int ORDERS      = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  bba_pkg::bba_cmd_t    cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bba_pkg::bba_out_t    out_data,
  output bba_pkg::bba_bk_sts_t sts
);

  localparam int MIN_LOG2  = HEADER_LOG2 + 1;
  localparam int HDR       = 1 << HEADER_LOG2;
  localparam int LEAF_LOG2 = ORDERS - 1;
  localparam int WB        = bba_pkg::WORD_LOG2;
  localparam int W         = 1 << WB;
  localparam int WIDX      = (LEAF_LOG2 > WB) ? LEAF_LOG2 - WB : 1;
  localparam int NWORD     = 1 << WIDX;
  localparam int IDXW      = WIDX + WB;
  localparam int OB        = $clog2(ORDERS);
  localparam int RW        = OB + WIDX;
  localparam int TROWS     = 1 << RW;
  localparam int NSLOT     = 1 << LEAF_LOG2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND    = 4'd1;
  localparam logic [3:0] S_SPL_RD  = 4'd2;
  localparam logic [3:0] S_SPL_WR  = 4'd3;
  localparam logic [3:0] S_MARK    = 4'd4;
  localparam logic [3:0] S_MARK_WR = 4'd5;
  localparam logic [3:0] S_FCHK    = 4'd6;
  localparam logic [3:0] S_MRG_RD  = 4'd7;
  localparam logic [3:0] S_MRG_WR  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  function automatic logic [RW-1:0] trow(logic [3:0] o, logic [LEAF_LOG2-1:0] x);
    logic [IDXW-1:0] xe;
    xe = IDXW'(x);
    return {o[OB-1:0], xe[IDXW-1:WB]};
  endfunction

  function automatic logic [WIDX-1:0] srow(logic [LEAF_LOG2-1:0] x);
    logic [IDXW-1:0] xe;
    xe = IDXW'(x);
    return xe[IDXW-1:WB];
  endfunction

  function automatic logic [W-1:0] bmask(logic [LEAF_LOG2-1:0] x);
    logic [IDXW-1:0] xe;
    xe = IDXW'(x);
    return W'(1) << xe[WB-1:0];
  endfunction

  // storage; a row whose flag is clear reads as all zero
  logic [W-1:0] tree_mem [TROWS];
  logic [W-1:0] slot_mem [NWORD];
  logic [3:0]   ord_mem  [NSLOT];
  logic [TROWS-1:0] tree_vld_r;
  logic [NWORD-1:0] slot_vld_r;
  logic             root_free_r, root_nxt;

  logic [3:0]           state_r, state_nxt;
  bba_pkg::bba_cmd_t    cmd_r, cmd_nxt;
  logic [3:0]           cur_r, cur_nxt, k_r, k_nxt;
  logic [LEAF_LOG2-1:0] x_r, x_nxt;
  bba_pkg::bba_out_t    res_r, res_nxt, out_data_r;
  logic                 out_valid_r, res_load, clr;

  logic          t_re, t_we, t_rvld_r;
  logic [RW-1:0] t_ra, t_wa;
  logic [W-1:0]  t_wd, t_rd_r, t_row;
  logic            s_re, s_we, s_rvld_r;
  logic [WIDX-1:0] s_ra, s_wa;
  logic [W-1:0]    s_wd, s_rd_r, s_row;
  logic                 o_we;
  logic [LEAF_LOG2-1:0] o_ra, o_wa;
  logic [3:0]           o_wd, o_rd_r;

  logic [ORDERS-1:0] ord_any;
  logic [3:0]        fnd_ord;
  logic              fnd_any;
  logic [RW-1:0]     fnd_base;
  logic [NWORD-1:0]  fnd_vld;
  logic [WIDX-1:0]   fnd_w;
  logic [WB-1:0]     low_bit;

  assign t_row = t_rvld_r ? t_rd_r : '0;
  assign s_row = s_rvld_r ? s_rd_r : '0;
  assign o_ra  = cmd.slot[LEAF_LOG2-1:0];

  // smallest order at or above the request with a free block, then its first row
  always_comb begin
    for (int j = 0; j < ORDERS - 1; j++) ord_any[j] = |tree_vld_r[j*NWORD +: NWORD];
    ord_any[ORDERS-1] = root_free_r;
    fnd_any = 1'b0;
    fnd_ord = '0;
    for (int j = ORDERS - 1; j >= 0; j--) begin
      if (ord_any[j] && (4'(j) >= cmd.order)) begin
        fnd_any = 1'b1;
        fnd_ord = 4'(j);
      end
    end
    fnd_base = {fnd_ord[OB-1:0], {WIDX{1'b0}}};
    fnd_vld  = tree_vld_r[fnd_base +: NWORD];
    fnd_w    = '0;
    for (int w = NWORD - 1; w >= 0; w--) begin
      if (fnd_vld[w]) fnd_w = WIDX'(w);
    end
    low_bit = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (t_row[b]) low_bit = WB'(b);
    end
  end

  always_comb begin
    logic [IDXW-1:0] xe;
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cur_nxt   = cur_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    res_nxt   = res_r;
    root_nxt  = root_free_r;
    cmd_pop   = 1'b0;
    res_load  = 1'b0;
    clr       = 1'b0;
    t_re = 1'b0; t_ra = '0; t_we = 1'b0; t_wa = '0; t_wd = '0;
    s_re = 1'b0; s_ra = '0; s_we = 1'b0; s_wa = '0; s_wd = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0;
    xe   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          k_nxt   = cmd.order;
          res_nxt = '0;
          state_nxt = S_DONE;
          case (cmd.kind)
            bba_pkg::CMD_ALLOC: begin
              if (!fnd_any) begin
                res_nxt.status = bba_pkg::ST_NO_FREE;
              end else if (fnd_ord == 4'(ORDERS - 1)) begin
                root_nxt  = 1'b0;
                cur_nxt   = fnd_ord;
                x_nxt     = '0;
                state_nxt = (fnd_ord > cmd.order) ? S_SPL_RD : S_MARK;
              end else begin
                xe        = {fnd_w, {WB{1'b0}}};
                x_nxt     = xe[LEAF_LOG2-1:0];
                cur_nxt   = fnd_ord;
                t_re      = 1'b1;
                t_ra      = {fnd_ord[OB-1:0], fnd_w};
                state_nxt = S_FIND;
              end
            end
            bba_pkg::CMD_FREE: begin
              x_nxt     = cmd.slot[LEAF_LOG2-1:0];
              s_re      = 1'b1;
              s_ra      = srow(cmd.slot[LEAF_LOG2-1:0]);
              state_nxt = S_FCHK;
            end
            bba_pkg::CMD_RESET: begin
              clr = 1'b1;
              res_nxt.granted_order = 4'(ORDERS - 1);
            end
            bba_pkg::CMD_TOO_LARGE: res_nxt.status = bba_pkg::ST_TOO_LARGE;
            bba_pkg::CMD_BAD_FREE:  res_nxt.status = bba_pkg::ST_BAD_FREE;
            default: ;
          endcase
        end
      end
      S_FIND: begin
        xe          = IDXW'(x_r);
        xe[WB-1:0]  = low_bit;
        x_nxt       = xe[LEAF_LOG2-1:0];
        t_we        = 1'b1;
        t_wa        = trow(cur_r, x_r);
        t_wd        = t_row & ~(W'(1) << low_bit);
        state_nxt   = (cur_r > k_r) ? S_SPL_RD : S_MARK;
      end
      S_SPL_RD: begin
        // descend to the left child, its right sibling becomes free
        cur_nxt   = cur_r - 4'd1;
        x_nxt     = x_r << 1;
        t_re      = 1'b1;
        t_ra      = trow(cur_r - 4'd1, x_r << 1);
        state_nxt = S_SPL_WR;
      end
      S_SPL_WR: begin
        t_we      = 1'b1;
        t_wa      = trow(cur_r, x_r);
        t_wd      = t_row | bmask(x_r | LEAF_LOG2'(1));
        state_nxt = (cur_r > k_r) ? S_SPL_RD : S_MARK;
      end
      S_MARK: begin
        x_nxt     = x_r << k_r;
        s_re      = 1'b1;
        s_ra      = srow(x_r << k_r);
        o_we      = 1'b1;
        o_wa      = x_r << k_r;
        o_wd      = k_r;
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        s_we    = 1'b1;
        s_wa    = srow(x_r);
        s_wd    = s_row | bmask(x_r);
        res_nxt.status         = bba_pkg::ST_OK;
        res_nxt.granted_offset = 15'((32'(x_r) << MIN_LOG2) + 32'(HDR));
        res_nxt.granted_order  = k_r;
        state_nxt = S_DONE;
      end
      S_FCHK: begin
        if ((s_row & bmask(x_r)) == '0) begin
          res_nxt.status = bba_pkg::ST_BAD_FREE;
          state_nxt      = S_DONE;
        end else begin
          s_we      = 1'b1;
          s_wa      = srow(x_r);
          s_wd      = s_row & ~bmask(x_r);
          k_nxt     = o_rd_r;
          cur_nxt   = o_rd_r;
          x_nxt     = x_r >> o_rd_r;
          state_nxt = S_MRG_RD;
        end
      end
      S_MRG_RD: begin
        if (cur_r == 4'(ORDERS - 1)) begin
          root_nxt  = 1'b1;
          res_nxt.status         = bba_pkg::ST_OK;
          res_nxt.granted_offset = cmd_r.user_offset;
          res_nxt.granted_order  = k_r;
          state_nxt = S_DONE;
        end else begin
          t_re      = 1'b1;
          t_ra      = trow(cur_r, x_r);
          state_nxt = S_MRG_WR;
        end
      end
      S_MRG_WR: begin
        t_we = 1'b1;
        t_wa = trow(cur_r, x_r);
        if ((t_row & bmask(x_r ^ LEAF_LOG2'(1))) != '0) begin
          // buddy free: absorb it and climb one order
          t_wd      = t_row & ~bmask(x_r ^ LEAF_LOG2'(1));
          cur_nxt   = cur_r + 4'd1;
          x_nxt     = x_r >> 1;
          state_nxt = S_MRG_RD;
        end else begin
          t_wd      = t_row | bmask(x_r);
          res_nxt.status         = bba_pkg::ST_OK;
          res_nxt.granted_offset = cmd_r.user_offset;
          res_nxt.granted_order  = k_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      tree_vld_r  <= '0;
      slot_vld_r  <= '0;
      root_free_r <= 1'b1;
    end else begin
      root_free_r <= root_nxt;
      if (t_we) tree_vld_r[t_wa] <= |t_wd;
      if (s_we) slot_vld_r[s_wa] <= |s_wd;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    cur_r <= cur_nxt;
    k_r   <= k_nxt;
    x_r   <= x_nxt;
    res_r <= res_nxt;
    if (res_load) out_data_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (t_we) tree_mem[t_wa] <= t_wd;
    if (t_re) begin
      t_rd_r   <= tree_mem[t_ra];
      t_rvld_r <= tree_vld_r[t_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_wa] <= s_wd;
    if (s_re) begin
      s_rd_r   <= slot_mem[s_ra];
      s_rvld_r <= slot_vld_r[s_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (o_we) ord_mem[o_wa] <= o_wd;
    o_rd_r <= ord_mem[o_ra];
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.busy     = (state_r != S_IDLE);
  assign sts.res_load = res_load;

endmodule

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// buddy block allocator, top level: front end, command queue, engine
// the engine takes a new word only once idle, after its split/merge walk over order bitmaps
// a two-entry queue takes words while the engine works or a result word waits
// rst_n (sync, active low) and the reset op both restore one free pool
`timescale 1ns / 1ps

module buddy_block_allocator_core #(
  parameter int HEADER_LOG2 = 3,
  parameter int ORDERS      = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bba_pkg::bba_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bba_pkg::bba_out_t out_data
);

  // classified command from the front end
  bba_pkg::bba_cmd_t    f_cmd;
  // queue head toward the engine
  bba_pkg::bba_cmd_t    q_cmd;
  logic                 q_valid, q_full, q_pop;
  // engine status for checks
  bba_pkg::bba_bk_sts_t bk_sts;

  // input stalls only when the queue is full
  assign in_stall = q_full;

  bba_front #(
    .HEADER_LOG2 (HEADER_LOG2),
    .ORDERS      (ORDERS)
  ) u_front (
    .in_word (in_data),
    .cmd     (f_cmd)
  );

  bba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_cmd   (f_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // engine: bitmap search, split, slot marking, merge, result register
  bba_back #(
    .HEADER_LOG2 (HEADER_LOG2),
    .ORDERS      (ORDERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .sts       (bk_sts)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !bk_sts.busy)
    else $error("engine took a word while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    bk_sts.res_load |-> (!out_valid || !out_stall))
    else $error("result word overwritten while stalled");

  a_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_sts.res_load))
    else $error("result valid without a load");
`endif

endmodule

// ===== tb/buddy_alloc_checker.sv =====
// buddy allocator checker: watches both channels, predicts each result word, compares
// depends on bba_pkg for the word types, op and status codes
`timescale 1ns / 1ps

module buddy_alloc_checker #(
  parameter int HEADER_LOG2 = 3,
  parameter int ORDERS      = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  bba_pkg::bba_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  bba_pkg::bba_out_t out_data,
  output int                fail_count,
  output int                pending_words
);

  localparam int NODES = (1 << ORDERS) - 1;
  localparam int SLOTS = 1 << (ORDERS - 1);
  localparam int MINL  = HEADER_LOG2 + 1;

  bit                tree_free [1:NODES];
  bit                slot_busy [SLOTS];
  bit [3:0]          slot_ord  [SLOTS];
  bba_pkg::bba_out_t pending_results [$];

  function automatic void pool_clear();
    for (int i = 1; i <= NODES; i++) tree_free[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 0;
      slot_ord[i] = 0;
    end
    tree_free[1] = 1;
  endfunction

  function automatic bit nfree(int n);
    return n >= 1 && n <= NODES && tree_free[n];
  endfunction

  function automatic bba_pkg::bba_out_t allocate(int bytes);
    bba_pkg::bba_out_t r;
    int need, k, j, node, start, d;
    r = '0;
    need = bytes + (1 << HEADER_LOG2);
    k = 0;
    while (k < ORDERS && (1 << (k + MINL)) < need) k++;
    if (k >= ORDERS) begin
      r.status = bba_pkg::ST_TOO_LARGE;
      return r;
    end
    node = 0;
    for (j = k; j < ORDERS; j++) begin
      d = ORDERS - 1 - j;
      for (int n = 1 << d; n < (2 << d); n++)
        if (nfree(n)) begin
          node = n;
          break;
        end
      if (node != 0) break;
    end
    if (node == 0) begin
      r.status = bba_pkg::ST_NO_FREE;
      return r;
    end
    tree_free[node] = 0;
    while (j > k) begin
      tree_free[2 * node + 1] = 1;
      node = 2 * node;
      j--;
    end
    d = ORDERS - 1 - k;
    start = (node - (1 << d)) << (k + MINL);
    slot_busy[(start >> MINL) & (SLOTS - 1)] = 1;
    slot_ord[(start >> MINL) & (SLOTS - 1)] = 4'(k);
    r.status = bba_pkg::ST_OK;
    r.granted_offset = 15'(start + (1 << HEADER_LOG2));
    r.granted_order = 4'(k);
    return r;
  endfunction

  function automatic bba_pkg::bba_out_t release_block(int uoff);
    bba_pkg::bba_out_t r;
    int start, slot, k, node;
    r = '0;
    r.status = bba_pkg::ST_BAD_FREE;
    if (uoff < (1 << HEADER_LOG2)) return r;
    start = uoff - (1 << HEADER_LOG2);
    if ((start & ((1 << MINL) - 1)) != 0) return r;
    slot = start >> MINL;
    if (slot >= SLOTS || !slot_busy[slot]) return r;
    k = slot_ord[slot];
    if (k >= ORDERS) return r;
    slot_busy[slot] = 0;
    node = (1 << (ORDERS - 1 - k)) + (start >> (k + MINL));
    // merge with the buddy all the way up while it is free
    while (node > 1 && nfree(node ^ 1)) begin
      tree_free[node ^ 1] = 0;
      node = node >> 1;
    end
    tree_free[node] = 1;
    r.status = bba_pkg::ST_OK;
    r.granted_offset = 15'(uoff);
    r.granted_order = 4'(k);
    return r;
  endfunction

  function automatic bba_pkg::bba_out_t predict_word(bba_pkg::bba_in_t w);
    bba_pkg::bba_out_t r;
    r = '0;
    case (w.op)
      bba_pkg::OP_ALLOC: r = allocate(w.request_bytes);
      bba_pkg::OP_FREE:  r = release_block(w.user_offset);
      bba_pkg::OP_RESET: begin
        pool_clear();
        r.granted_order = 4'(ORDERS - 1);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_words = pending_results.size();

  initial begin
    fail_count = 0;
    pool_clear();
  end

  always @(posedge clk) begin
    bba_pkg::bba_out_t exp_w;
    if (rst_n && in_valid && !in_stall)
      pending_results.push_back(predict_word(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", out_data);
        fail_count++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_data.status !== exp_w.status) begin
          $error("status: expected %0d actual %0d", exp_w.status, out_data.status);
          fail_count++;
        end
        if (out_data.granted_offset !== exp_w.granted_offset) begin
          $error("granted_offset: expected %0d actual %0d",
                 exp_w.granted_offset, out_data.granted_offset);
          fail_count++;
        end
        if (out_data.granted_order !== exp_w.granted_order) begin
          $error("granted_order: expected %0d actual %0d",
                 exp_w.granted_order, out_data.granted_order);
          fail_count++;
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// testbench top for the buddy block allocator: clock, reset, stimulus, verdict
// depends on bba_pkg, buddy_block_allocator_core and buddy_alloc_checker
`timescale 1ns / 1ps

module tb;

  localparam int ORDERS = 12;
  localparam int RANDOM_WORDS = 1810;
  localparam longint CYCLE_LIMIT = 1500000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_stall;
  bba_pkg::bba_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1;
  bba_pkg::bba_out_t out_data;
  int       fail_count, pending_words;
  longint   cycle_count = 0;
  bit       hold_off_req = 0;   // sender asks the receiver for one long stall
  bit       quiet_rx = 0;       // receiver takes every word at once during this stretch
  int       live_offsets [$];   // offsets handed out so far, for well-formed frees

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  buddy_block_allocator_core #(.HEADER_LOG2(3), .ORDERS(ORDERS)) u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  buddy_alloc_checker #(.HEADER_LOG2(3), .ORDERS(ORDERS)) u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending_words
  );

  // track granted offsets so that frees mostly hit live blocks
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall && out_data.status == bba_pkg::ST_OK &&
        out_data.granted_offset != 0 && live_offsets.size() < 256)
      live_offsets.push_back(out_data.granted_offset);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // hand one word over; the idle gap comes first, and valid stays up between words without a gap
  task automatic send_word(logic [1:0] op, int bytes, int uoff, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_data.op <= op;
    in_data.request_bytes <= 16'(bytes);
    in_data.user_offset <= 15'(uoff);
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic random_word(bit idle);
    int pick, uoff, sz;
    pick = $urandom_range(0, 99);
    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32768) : $urandom_range(0, 600);
    if (pick < 50) begin
      send_word(bba_pkg::OP_ALLOC, sz, 0, idle);
    end else if (pick < 88 && live_offsets.size() > 0) begin
      // well-formed free, sometimes of an already freed block
      pick = $urandom_range(0, live_offsets.size() - 1);
      uoff = live_offsets[pick];
      if ($urandom_range(0, 5) != 0) live_offsets.delete(pick);
      send_word(bba_pkg::OP_FREE, $urandom_range(0, 65535), uoff, idle);
    end else if (pick < 96) begin
      send_word(bba_pkg::OP_FREE, 0, $urandom_range(0, 32767), idle);
    end else if (pick < 98) begin
      live_offsets.delete();
      send_word(bba_pkg::OP_RESET, $urandom_range(0, 65535), $urandom_range(0, 32767), idle);
    end else begin
      send_word(bba_pkg::OP_SPARE, $urandom_range(0, 65535), $urandom_range(0, 32767), idle);
    end
  endtask

  // receiver: random stall per word, one long hold-off on request
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        hold_off_req = 0;
      end
      wait_n = quiet_rx ? 0 : $urandom_range(0, 16);
      if (wait_n > 0) begin
        out_stall <= 1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, each op, each special case
    send_word(bba_pkg::OP_ALLOC, 0, 0, 0);            // smallest order
    send_word(bba_pkg::OP_ALLOC, 8, 0, 0);            // exactly one smallest block
    send_word(bba_pkg::OP_ALLOC, 9, 0, 0);            // one order up
    send_word(bba_pkg::OP_ALLOC, 32768, 0, 0);        // too large
    send_word(bba_pkg::OP_ALLOC, 65535, 0, 0);        // too large, all bits set
    send_word(bba_pkg::OP_ALLOC, 32760, 0, 0);        // whole pool, exhausted now
    send_word(bba_pkg::OP_FREE, 0, 8, 0);             // free first block
    send_word(bba_pkg::OP_FREE, 0, 8, 0);             // double free
    send_word(bba_pkg::OP_FREE, 0, 0, 0);             // below header
    send_word(bba_pkg::OP_FREE, 0, 12, 0);            // off slot boundary
    send_word(bba_pkg::OP_FREE, 0, 32767, 0);         // off slot boundary, near the end of the pool
    send_word(bba_pkg::OP_FREE, 0, 24, 0);            // free the second smallest block, merges
    send_word(bba_pkg::OP_FREE, 0, 40, 0);            // free the order-one block, merges to root
    send_word(bba_pkg::OP_SPARE, 65535, 32767, 0);    // unused op
    send_word(bba_pkg::OP_RESET, 0, 0, 0);
    send_word(bba_pkg::OP_ALLOC, 32760, 0, 0);        // whole pool
    send_word(bba_pkg::OP_FREE, 0, 8, 0);             // merges back to root
    // exhaust order eight
    for (int i = 0; i < 9; i++) send_word(bba_pkg::OP_ALLOC, 4000, 0, 0);
    send_word(bba_pkg::OP_RESET, 0, 0, 0);
    drain();

    // fill the queue while the receiver holds off
    hold_off_req = 1;
    for (int i = 0; i < 10; i++) random_word(0);
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 600) begin
        // a stretch with no idling on either side
        quiet_rx = 1;
        for (int k = 0; k < 100; k++) random_word(0);
        quiet_rx = 0;
        drain();
      end
      if (i % 400 == 399) drain();
      random_word(1);
    end

    drain();
    in_valid <= 0;
    repeat (60) @(negedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
